FILE: rtl/positional_list_engine_assert.svh
// Assertion macros for the positional list engine.
// Each use sits inside a module that has clk and rst_n.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLE_ASSERT(lbl, prop, msg)
`define PLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/ple_pkg.sv
package ple_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int FUNC_W    = 4;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 5;
    localparam int FIDX_W    = 4;
    localparam int CNT_W     = 5;
    localparam int STAT_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 4'd0,
        FN_INS_BACK  = 4'd1,
        FN_INS_AT    = 4'd2,
        FN_EXT_FRONT = 4'd3,
        FN_EXT_BACK  = 4'd4,
        FN_EXT_AT    = 4'd5,
        FN_RD_BACK   = 4'd6,
        FN_RD_AT     = 4'd7,
        FN_FIND      = 4'd8
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] data_word;
        logic [POS_W-1:0]         position;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_word;
        logic [FIDX_W-1:0]        found_index;
        status_t                  status;
        logic [CNT_W-1:0]         entry_count;
    } out_item_t;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } cell_ctl_t;

endpackage

FILE: rtl/ple_cell.sv
module ple_cell #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  ple_pkg::cell_ctl_t             ctl,
    input  logic [$clog2(DEPTH)-1:0]       idx,
    input  logic [$clog2(DEPTH)-1:0]       at,
    input  logic [$clog2(DEPTH+1)-1:0]     cnt,
    input  logic [$clog2(DEPTH)-1:0]       pick,
    input  logic [ple_pkg::WORD_W-1:0]     key,
    input  logic [ple_pkg::WORD_W-1:0]     left,
    input  logic [ple_pkg::WORD_W-1:0]     right,
    output logic [ple_pkg::WORD_W-1:0]     value,
    output logic [ple_pkg::WORD_W-1:0]     sel_word,
    output logic                           match
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [ple_pkg::WORD_W-1:0] value_reg;
    logic [ple_pkg::WORD_W-1:0] value_next;
    logic [CW-1:0]              idx_c;
    logic [CW-1:0]              at_c;
    logic                       occupied;

    assign idx_c    = CW'(idx);
    assign at_c     = CW'(at);
    assign occupied = idx_c < cnt;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins)
        begin
            if (idx == at)
                value_next = key;
            else if (idx_c > at_c && idx_c <= cnt)
                value_next = left;
        end
        else if (ctl.ext)
        begin
            // close the gap: everything past the pick moves one toward the front
            if (idx_c >= at_c && idx_c + CW'(1) < cnt)
                value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value    = value_reg;
    assign sel_word = (idx == pick) ? value_reg : '0;
    assign match    = occupied && (value_reg == key);

endmodule

FILE: rtl/positional_list_engine.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data  (func, data_word, position)
// out     | output    | out_valid / out_ready  | out_data (out_word, found_index, status,
//         |           |                        |           entry_count)
// One word per clock while the output is not stalled: every operation finishes in the
// cycle it is accepted; the row of cells shifts and compares in parallel and the result
// lands in the output register, so out_valid rises in the cycle after acceptance.
// Reset clears the entry count and the output valid; cell contents are left as they are.
// A stalled output holds its word and keeps in_ready low until out_ready returns.
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ple_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ple_pkg::out_item_t out_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
    localparam int XW = (IW > ple_pkg::FIDX_W) ? IW : ple_pkg::FIDX_W;
    localparam int OW = (CW > ple_pkg::CNT_W) ? CW : ple_pkg::CNT_W;

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       out_valid_reg;
    ple_pkg::out_item_t         out_reg;

    logic                       fire;
    ple_pkg::cell_ctl_t         ctl;
    logic [CW-1:0]              at_c;
    logic [CW-1:0]              pick_c;
    logic [PW-1:0]              pos_p;
    logic                       pos_ge;
    logic                       full;
    logic                       empty;
    logic [CW-1:0]              last;
    ple_pkg::status_t           status;
    logic [ple_pkg::WORD_W-1:0] word_res;
    logic [XW-1:0]              idx_res;
    logic [OW-1:0]              cnt_o;

    logic [ple_pkg::WORD_W-1:0] cell_val [DEPTH];
    logic [ple_pkg::WORD_W-1:0] cell_sel [DEPTH];
    logic [DEPTH-1:0]           match_vec;
    logic [DEPTH-1:0]           first_hit;
    logic [ple_pkg::WORD_W-1:0] sel_or;
    logic [XW-1:0]              first_idx;
    logic                       hit;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [ple_pkg::WORD_W-1:0] left_w;
            logic [ple_pkg::WORD_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_val[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_val[g+1];
            end

            ple_cell #(.DEPTH(DEPTH)) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .idx      (IW'(g)),
                .at       (at_c[IW-1:0]),
                .cnt      (count_reg),
                .pick     (pick_c[IW-1:0]),
                .key      (in_data.data_word),
                .left     (left_w),
                .right    (right_w),
                .value    (cell_val[g]),
                .sel_word (cell_sel[g]),
                .match    (match_vec[g])
            );
        end
    endgenerate

    // isolate the lowest matching cell
    assign first_hit = match_vec & (~match_vec + DEPTH'(1));
    assign hit       = |match_vec;

    always_comb
    begin
        sel_or    = '0;
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_or = sel_or | cell_sel[i];
            if (first_hit[i])
                first_idx = first_idx | XW'(i);
        end
    end

    assign pos_p  = PW'(in_data.position);
    assign pos_ge = pos_p >= PW'(count_reg);
    assign full   = count_reg == CW'(DEPTH);
    assign empty  = count_reg == '0;
    assign last   = count_reg - CW'(1);

    always_comb
    begin
        ctl        = '0;
        at_c       = '0;
        pick_c     = '0;
        status     = ple_pkg::ST_OK;
        word_res   = '0;
        idx_res    = '0;
        count_next = count_reg;
        unique case (ple_pkg::func_t'(in_data.func)) inside
            ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_AT:
            begin
                if (full)
                    status = ple_pkg::ST_FULL;
                else
                begin
                    ctl.ins    = fire;
                    count_next = count_reg + CW'(1);
                    if (in_data.func == ple_pkg::FN_INS_FRONT)
                        at_c = '0;
                    else if (in_data.func == ple_pkg::FN_INS_BACK || pos_ge)
                        at_c = count_reg;
                    else
                        at_c = CW'(pos_p);
                end
            end
            ple_pkg::FN_EXT_FRONT, ple_pkg::FN_EXT_BACK, ple_pkg::FN_EXT_AT:
            begin
                if (empty)
                    status = ple_pkg::ST_MISS;
                else
                begin
                    ctl.ext    = fire;
                    count_next = last;
                    if (in_data.func == ple_pkg::FN_EXT_FRONT)
                        at_c = '0;
                    else if (in_data.func == ple_pkg::FN_EXT_BACK || pos_ge)
                        at_c = last;
                    else
                        at_c = CW'(pos_p);
                    pick_c   = at_c;
                    word_res = sel_or;
                end
            end
            ple_pkg::FN_RD_BACK:
            begin
                if (empty)
                    status = ple_pkg::ST_MISS;
                else
                begin
                    pick_c   = last;
                    word_res = sel_or;
                end
            end
            ple_pkg::FN_RD_AT:
            begin
                if (pos_ge)
                    status = ple_pkg::ST_MISS;
                else
                begin
                    pick_c   = CW'(pos_p);
                    word_res = sel_or;
                end
            end
            ple_pkg::FN_FIND:
            begin
                if (hit)
                begin
                    word_res = in_data.data_word;
                    idx_res  = first_idx;
                end
                else
                    status = ple_pkg::ST_MISS;
            end
            default:
            begin
                status = ple_pkg::ST_MISS;
            end
        endcase
    end

    assign cnt_o = OW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.out_word    <= word_res;
            out_reg.found_index <= idx_res[ple_pkg::FIDX_W-1:0];
            out_reg.status      <= status;
            out_reg.entry_count <= cnt_o[ple_pkg::CNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PLE_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "entry count past depth")
    `PLE_ASSERT(a_full_holds, fire && status == ple_pkg::ST_FULL |=> count_reg == $past(count_reg), "refused insert changed count")
    `PLE_ASSERT(a_ext_dec, fire && ctl.ext |=> count_reg + CW'(1) == $past(count_reg), "extract did not drop count by one")
    `PLE_ASSERT(a_miss_zero, out_valid_reg && out_reg.status != ple_pkg::ST_OK |-> out_reg.out_word == '0, "non-ok result carries a word")
    `PLE_ASSERT_ALWAYS(a_one_op, !(ctl.ins && ctl.ext), "insert and extract together")

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int STALL_LIMIT = 5000;

    // Expected-result store plus a shadow copy of the list contents
    class list_scoreboard;
        logic [WORD_W-1:0] cells [LIST_DEPTH];
        int unsigned       fill;
        out_item_t         expected_q [$];
        int                fail_count;

        function new();
            fill       = 0;
            fail_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function out_item_t apply_op(in_item_t w);
            out_item_t   r;
            int unsigned at;
            int unsigned pos;
            r        = '0;
            r.status = ST_OK;
            pos      = 32'(w.position);
            case (w.func) inside
                FN_INS_FRONT, FN_INS_BACK, FN_INS_AT:
                begin
                    if (fill >= LIST_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        if (w.func == FN_INS_FRONT)
                            at = 0;
                        else if (w.func == FN_INS_BACK || pos >= fill)
                            at = fill;
                        else
                            at = pos;
                        for (int unsigned i = fill; i > at; i--)
                            cells[i] = cells[i-1];
                        cells[at] = w.data_word;
                        fill++;
                    end
                end
                FN_EXT_FRONT, FN_EXT_BACK, FN_EXT_AT:
                begin
                    if (fill == 0)
                    begin
                        r.status = ST_MISS;
                    end
                    else
                    begin
                        if (w.func == FN_EXT_FRONT)
                            at = 0;
                        else if (w.func == FN_EXT_BACK || pos >= fill)
                            at = fill - 1;
                        else
                            at = pos;
                        r.out_word = cells[at];
                        for (int unsigned i = at; i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                    end
                end
                FN_RD_BACK:
                begin
                    if (fill == 0)
                        r.status = ST_MISS;
                    else
                        r.out_word = cells[fill-1];
                end
                FN_RD_AT:
                begin
                    if (pos < fill)
                        r.out_word = cells[pos];
                    else
                        r.status = ST_MISS;
                end
                FN_FIND:
                begin
                    r.status = ST_MISS;
                    for (int unsigned i = 0; i < fill; i++)
                    begin
                        if (cells[i] == w.data_word)
                        begin
                            r.status      = ST_OK;
                            r.out_word    = w.data_word;
                            r.found_index = i[FIDX_W-1:0];
                            break;
                        end
                    end
                end
                default: r.status = ST_MISS;
            endcase
            r.entry_count = fill[CNT_W-1:0];
            return r;
        endfunction

        function void note_input(in_item_t w);
            expected_q.push_back(apply_op(w));
        endfunction

        function void check_result(out_item_t act);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result word: expected none actual %p", $time, act);
                fail_count++;
                return;
            end
            exp = expected_q.pop_front();
            if (act.out_word !== exp.out_word)
            begin
                $display("%0t out_word: expected %0d actual %0d",
                         $time, exp.out_word, act.out_word);
                fail_count++;
            end
            if (act.found_index !== exp.found_index)
            begin
                $display("%0t found_index: expected %0d actual %0d",
                         $time, exp.found_index, act.found_index);
                fail_count++;
            end
            if (act.status !== exp.status)
            begin
                $display("%0t status: expected %0d actual %0d",
                         $time, exp.status, act.status);
                fail_count++;
            end
            if (act.entry_count !== exp.entry_count)
            begin
                $display("%0t entry_count: expected %0d actual %0d",
                         $time, exp.entry_count, act.entry_count);
                fail_count++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    list_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    positional_list_engine #(.DEPTH(LIST_DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic in_item_t mk_word(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] d,
                                         logic [POS_W-1:0] p);
        in_item_t w;
        w.func      = f;
        w.data_word = d;
        w.position  = p;
        return w;
    endfunction

    // small pool keeps duplicates and find hits common
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9)) inside
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            [3:5]:   return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // mode 0 fills toward full, mode 1 drains toward empty, mode 2 mixes evenly
    function automatic in_item_t gen_word(int mode);
        int                roll;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            f = FUNC_W'($urandom_range(9, 15));
        else if (mode == 0)
            f = (roll < 65) ? FUNC_W'($urandom_range(0, 2)) : FUNC_W'($urandom_range(3, 8));
        else if (mode == 1)
            f = (roll < 60) ? FUNC_W'($urandom_range(3, 5)) : FUNC_W'($urandom_range(0, 8));
        else
            f = FUNC_W'($urandom_range(0, 8));
        p = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 31))
                                        : POS_W'($urandom_range(0, 17));
        return mk_word(f, pick_value(), p);
    endfunction

    task automatic send_word(input in_item_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        // let the monitor log the last accepted word first
        @(negedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int s_pct, int r_pct, int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < count; k++)
            send_word(gen_word((k / 48) % 3));
        drain_results();
    endtask

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 69;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every removal, read and find misses
        send_word(mk_word(FN_EXT_FRONT, 32'd0, 5'd0));
        send_word(mk_word(FN_EXT_BACK, 32'd0, 5'd0));
        send_word(mk_word(FN_EXT_AT, 32'd0, 5'd3));
        send_word(mk_word(FN_RD_BACK, 32'd0, 5'd0));
        send_word(mk_word(FN_RD_AT, 32'd0, 5'd0));
        send_word(mk_word(FN_FIND, 32'd0, 5'd0));
        send_word(mk_word(4'd9, 32'hffff_ffff, 5'd31));
        send_word(mk_word(4'd15, 32'h0, 5'd0));
        // build a short list, positions past the count append; then read, find and extract
        send_word(mk_word(FN_INS_FRONT, 32'h7fff_ffff, 5'd0));
        send_word(mk_word(FN_INS_BACK, 32'h8000_0000, 5'd0));
        send_word(mk_word(FN_INS_AT, 32'd5, 5'd1));
        send_word(mk_word(FN_INS_AT, 32'hffff_ffff, 5'd16));
        send_word(mk_word(FN_INS_AT, 32'd5, 5'd31));
        send_word(mk_word(FN_RD_AT, 32'd0, 5'd2));
        send_word(mk_word(FN_RD_AT, 32'd0, 5'd5));
        send_word(mk_word(FN_RD_AT, 32'd0, 5'd31));
        send_word(mk_word(FN_RD_BACK, 32'd0, 5'd0));
        send_word(mk_word(FN_FIND, 32'd5, 5'd0));
        send_word(mk_word(FN_FIND, 32'd1234, 5'd0));
        send_word(mk_word(FN_EXT_AT, 32'd0, 5'd1));
        send_word(mk_word(FN_EXT_AT, 32'd0, 5'd31));
        send_word(mk_word(FN_EXT_BACK, 32'd0, 5'd0));
        send_word(mk_word(FN_EXT_FRONT, 32'd0, 5'd0));
        drain_results();

        run_phase(17, 69, 342);
        run_phase(69, 17, 342);
        run_phase(0, 0, 342);

        repeat (10) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
